// File: rtl/srh_pkg.sv
package srh_pkg;

    localparam int MAX_SCORE  = 1023;
    localparam int COUNT_BITS = 24;

    localparam int DEPTH   = MAX_SCORE + 1;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SCORE_W = 11;
    localparam int RANK_W  = 25;
    localparam int SAME_W  = 24;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [IDX_W-1:0]      idx_t;

    // command broadcast to every cell while a token walks the chain
    typedef struct packed {
        logic upd;       // update transaction
        logic dec_old;   // decrement the old bucket
        logic up;        // old < new: increment above-counts in [lo, hi)
        logic down;      // old > new: decrement above-counts in [lo, hi)
        idx_t score;
        idx_t old;
        idx_t lo;
        idx_t hi;
    } bcast_t;

    // token passed from cell to cell, carrying the answer once it is picked up
    typedef struct packed {
        logic              valid;
        logic [RANK_W-1:0] rank;
        logic [SAME_W-1:0] same;
    } tok_t;

    function automatic count_t sat_inc(input count_t v);
        return (v == COUNT_MAX) ? v : v + count_t'(1);
    endfunction

    function automatic count_t sat_dec(input count_t v);
        return (v == '0) ? v : v - count_t'(1);
    endfunction

    function automatic logic [RANK_W-1:0] make_rank(input count_t above);
        logic [COUNT_BITS:0] sum;
        sum = {1'b0, above} + {{COUNT_BITS{1'b0}}, 1'b1};
        return RANK_W'(sum);
    endfunction

endpackage

// File: rtl/srh_cell.sv
module srh_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  srh_pkg::idx_t   cell_idx,
    input  srh_pkg::bcast_t bc,
    input  srh_pkg::tok_t   tok_in,
    output srh_pkg::tok_t   tok_out
);
    import srh_pkg::*;

    count_t at_reg, at_next;
    count_t above_reg, above_next;
    tok_t   tok_reg, tok_next;
    logic   in_rng;
    logic   hit;

    assign in_rng = (cell_idx >= bc.lo) && (cell_idx < bc.hi);
    assign hit    = tok_in.valid && (cell_idx == bc.score);

    always_comb begin
        at_next    = at_reg;
        above_next = above_reg;
        if (tok_in.valid && bc.upd) begin
            // old bucket first, then new bucket, so old == new nets out right
            if (bc.dec_old && (cell_idx == bc.old)) begin
                at_next = sat_dec(at_next);
            end
            if (cell_idx == bc.score) begin
                at_next = sat_inc(at_next);
            end
            if (in_rng && bc.up) begin
                above_next = sat_inc(above_reg);
            end else if (in_rng && bc.down) begin
                above_next = sat_dec(above_reg);
            end
        end
        tok_next = tok_in;
        if (hit) begin
            tok_next.rank = make_rank(above_next);
            tok_next.same = SAME_W'(at_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            at_reg        <= '0;
            above_reg     <= '0;
            tok_reg.valid <= 1'b0;
        end else begin
            at_reg        <= at_next;
            above_reg     <= above_next;
            tok_reg.valid <= tok_next.valid;
        end
        tok_reg.rank <= tok_next.rank;
        tok_reg.same <= tok_next.same;
    end

    assign tok_out = tok_reg;

endmodule

// File: rtl/score_rank_histogram_unit.sv
// Rank lookup over a histogram of user scores. Each score 0..MAX_SCORE owns
// one cell holding the count of users at that score and the count of users
// above it. A transaction launches a token into the row of cells; the token
// moves one cell per clock while every cell applies the broadcast command to
// its own counts, and the cell matching the score drops its answer into the
// token. A query or update is answered once the token has walked all
// MAX_SCORE + 1 cells and then passed two output stages, the pending and
// output registers; a transaction with an out-of-range score skips the
// walk and goes straight to the pending register. One transaction is in
// flight at a time, and a new one is accepted while the previous result
// still waits on the output. All counts are cleared by reset directly,
// with no clearing pass.
module score_rank_histogram_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_command,
    input  logic [srh_pkg::SCORE_W-1:0]  s_score,
    input  logic [srh_pkg::SCORE_W-1:0]  s_old_score,
    input  logic                         s_old_valid,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_error,
    output logic [srh_pkg::RANK_W-1:0]   m_rank,
    output logic [srh_pkg::SAME_W-1:0]   m_same_score_count
);
    import srh_pkg::*;

    localparam logic [SCORE_W-1:0] MAX_S = SCORE_W'(MAX_SCORE);

    tok_t   tok [0:DEPTH];

    logic   busy_reg, busy_next;
    logic   start_reg, start_next;
    bcast_t bc_reg, bc_next;

    logic              pend_valid_reg, pend_valid_next;
    logic              pend_error_reg, pend_error_next;
    logic [RANK_W-1:0] pend_rank_reg, pend_rank_next;
    logic [SAME_W-1:0] pend_same_reg, pend_same_next;

    logic              m_valid_reg, m_valid_next;
    logic              m_error_reg, m_error_next;
    logic [RANK_W-1:0] m_rank_reg, m_rank_next;
    logic [SAME_W-1:0] m_same_reg, m_same_next;

    logic accept;
    logic in_err;
    logic out_free;
    idx_t sc_idx;
    idx_t old_idx;

    assign s_ready  = !busy_reg;
    assign accept   = s_valid && s_ready;
    assign in_err   = (s_score > MAX_S)
                   || (s_command && s_old_valid && (s_old_score > MAX_S));
    assign out_free = !m_valid_reg || m_ready;
    assign sc_idx   = s_score[IDX_W-1:0];
    assign old_idx  = s_old_valid ? s_old_score[IDX_W-1:0] : '0;

    assign tok[0].valid = start_reg;
    assign tok[0].rank  = '0;
    assign tok[0].same  = '0;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        srh_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (IDX_W'(i)),
            .bc       (bc_reg),
            .tok_in   (tok[i]),
            .tok_out  (tok[i+1])
        );
    end

    always_comb begin
        busy_next       = busy_reg;
        start_next      = 1'b0;
        bc_next         = bc_reg;
        pend_valid_next = pend_valid_reg;
        pend_error_next = pend_error_reg;
        pend_rank_next  = pend_rank_reg;
        pend_same_next  = pend_same_reg;
        m_valid_next    = m_valid_reg;
        m_error_next    = m_error_reg;
        m_rank_next     = m_rank_reg;
        m_same_next     = m_same_reg;

        if (accept) begin
            busy_next = 1'b1;
            if (in_err) begin
                pend_valid_next = 1'b1;
                pend_error_next = 1'b1;
                pend_rank_next  = '0;
                pend_same_next  = '0;
            end else begin
                start_next      = 1'b1;
                bc_next.upd     = s_command;
                bc_next.dec_old = s_command && s_old_valid;
                bc_next.up      = s_command && (old_idx < sc_idx);
                bc_next.down    = s_command && (old_idx > sc_idx);
                bc_next.score   = sc_idx;
                bc_next.old     = old_idx;
                bc_next.lo      = (old_idx < sc_idx) ? old_idx : sc_idx;
                bc_next.hi      = (old_idx < sc_idx) ? sc_idx : old_idx;
            end
        end

        // token leaving the last cell carries the answer
        if (tok[DEPTH].valid) begin
            pend_valid_next = 1'b1;
            pend_error_next = 1'b0;
            pend_rank_next  = tok[DEPTH].rank;
            pend_same_next  = tok[DEPTH].same;
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (pend_valid_reg && out_free) begin
            m_valid_next    = 1'b1;
            m_error_next    = pend_error_reg;
            m_rank_next     = pend_rank_reg;
            m_same_next     = pend_same_reg;
            pend_valid_next = 1'b0;
            busy_next       = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg       <= 1'b0;
            start_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            busy_reg       <= busy_next;
            start_reg      <= start_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        bc_reg         <= bc_next;
        pend_error_reg <= pend_error_next;
        pend_rank_reg  <= pend_rank_next;
        pend_same_reg  <= pend_same_next;
        m_error_reg    <= m_error_next;
        m_rank_reg     <= m_rank_next;
        m_same_reg     <= m_same_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_error            = m_error_reg;
    assign m_rank             = m_rank_reg;
    assign m_same_score_count = m_same_reg;

endmodule
